@@ src/fbwa_pkg.sv @@
package fbwa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int SPACE_W    = 16;
  localparam int NUM_W      = 7;
  localparam int FUNC_W     = 3;
  localparam int STAT_W     = 2;
  localparam int CHOSEN_W   = 6;
  localparam int IDX_IN_W   = 6;
  localparam int AMT_W      = 16;

  localparam logic [FUNC_W-1:0] FN_SET   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FIRST = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WORST = 3'd2;
  localparam logic [FUNC_W-1:0] FN_BEST  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic CFG_NUM_BLOCKS = 1'b0;
  localparam logic CFG_BLOCK_SIZE = 1'b1;

  // Command held steady for the whole pass through the row of cells.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [BLK_W-1:0]   idx;
    logic [AMT_W-1:0]   amt;
    logic [NUM_W-1:0]   n;
  } cmd_t;

  // Best candidate so far, handed from cell to cell.
  typedef struct packed {
    logic               found;
    logic [BLK_W-1:0]   pick;
    logic [SPACE_W-1:0] val;
  } cand_t;

  typedef struct packed {
    logic               en;
    logic [BLK_W-1:0]   idx;
    logic [SPACE_W-1:0] val;
  } wr_t;

endpackage

@@ src/fbwa_cell.sv @@
module fbwa_cell
  import fbwa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BLK_W-1:0] my_idx_i,
  input  cmd_t             cmd_i,
  input  wr_t              wr_i,
  input  logic             tok_i,
  input  cand_t            cand_i,
  output logic             tok_o,
  output cand_t            cand_o
);

  logic [SPACE_W-1:0] space_q;
  logic               tok_q;
  cand_t              cand_q;
  cand_t              cand_d;
  logic               fits;
  logic               take;

  assign fits = ({1'b0, my_idx_i} < cmd_i.n) && (space_q >= cmd_i.amt);

  always_comb begin
    case (cmd_i.func)
      FN_FIRST: take = fits && !cand_i.found;
      FN_WORST: take = fits && (!cand_i.found || space_q > cand_i.val);
      FN_BEST:  take = fits && (!cand_i.found || space_q < cand_i.val);
      FN_READ:  take = (my_idx_i == cmd_i.idx);
      default:  take = 1'b0;
    endcase
    if (take) begin
      cand_d = '{found: 1'b1, pick: my_idx_i, val: space_q};
    end else begin
      cand_d = cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q <= '0;
      tok_q   <= 1'b0;
      cand_q  <= '0;
    end else begin
      tok_q <= tok_i;
      if (tok_i) begin
        cand_q <= cand_d;
      end
      if (wr_i.en && wr_i.idx == my_idx_i) begin
        space_q <= wr_i.val;
      end
    end
  end

  assign tok_o  = tok_q;
  assign cand_o = cand_q;

endmodule

@@ src/fit_policy_block_allocator_unit.sv @@
// Fit-policy block allocator: keeps the free space of MAX_BLOCKS blocks in a
// row of cells and serves set, first/best/worst fit and read requests.
// Requests enter on the s_axis channel, one result per request leaves on
// m_axis. Block count and block size are written on the cfg channel, which
// is always ready and is to be used only while the unit is idle.
// Each request is carried through the whole row by a token that moves one
// cell per cycle, the running candidate following it; the row length sets
// the latency. A new request is accepted only once the previous one has
// left the finishing state, so requests are handled one at a time.
// The result sits in an output register; if the receiver stalls, a finished
// request waits there while the next request is accepted and searched, and
// that one is held in the last cell until the register frees.
// Reset clears all free space to zero, sets 64 blocks of size 4096 and
// leaves the unit idle and ready.
module fit_policy_block_allocator_unit
  import fbwa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // func[2:0], block_index[8:3], amount[24:9]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // status[1:0], chosen_block[7:2], space_left[23:8]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e             state_q;
  logic [NUM_W-1:0]   num_blocks_q;
  logic [SPACE_W-1:0] block_size_q;
  cmd_t               cmd_q;
  wr_t                wr_q;
  logic               start_q;
  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [CHOSEN_W-1:0] out_blk_q;
  logic [SPACE_W-1:0] out_space_q;

  logic [MAX_BLOCKS:0] tok;
  cand_t               cand [MAX_BLOCKS+1];
  logic [NUM_W-1:0]    n_eff;
  logic                in_acc;
  logic                out_free;
  logic                fin_go;
  cand_t               last;
  logic                in_range;
  logic                too_big;
  logic [SPACE_W-1:0]  set_val;
  logic [SPACE_W-1:0]  fit_val;
  logic [STAT_W-1:0]   res_status;
  logic [BLK_W-1:0]    res_blk;
  logic [SPACE_W-1:0]  res_space;
  wr_t                 res_wr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fin_go        = (state_q == S_FIN) && out_free;

  assign n_eff = (num_blocks_q > NUM_W'(MAX_BLOCKS)) ? NUM_W'(MAX_BLOCKS) : num_blocks_q;

  assign tok[0]  = start_q;
  assign cand[0] = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fbwa_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (BLK_W'(g)),
      .cmd_i    (cmd_q),
      .wr_i     (wr_q),
      .tok_i    (tok[g]),
      .cand_i   (cand[g]),
      .tok_o    (tok[g+1]),
      .cand_o   (cand[g+1])
    );
  end

  assign last     = cand[MAX_BLOCKS];
  assign in_range = ({1'b0, cmd_q.idx} < cmd_q.n);
  assign too_big  = (cmd_q.amt > block_size_q);
  assign set_val  = block_size_q - cmd_q.amt;
  assign fit_val  = last.val - cmd_q.amt;

  always_comb begin
    res_status = ST_RANGE;
    res_blk    = cmd_q.idx;
    res_space  = '0;
    res_wr     = '0;
    case (cmd_q.func)
      FN_SET: begin
        if (in_range) begin
          res_wr.en  = 1'b1;
          res_wr.idx = cmd_q.idx;
          if (too_big) begin
            res_wr.val = '0;
          end else begin
            res_wr.val = set_val;
            res_status = ST_OK;
            res_space  = set_val;
          end
        end
      end
      FN_READ: begin
        if (in_range) begin
          res_status = ST_OK;
          res_space  = last.val;
        end
      end
      FN_FIRST, FN_WORST, FN_BEST: begin
        if (last.found) begin
          res_status = ST_OK;
          res_blk    = last.pick;
          res_space  = fit_val;
          res_wr     = '{en: 1'b1, idx: last.pick, val: fit_val};
        end else begin
          res_status = ST_NOFIT;
          res_blk    = '0;
        end
      end
      default: begin
        res_status = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      num_blocks_q <= NUM_W'(64);
      block_size_q <= SPACE_W'(4096);
      cmd_q        <= '0;
      wr_q         <= '0;
      start_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_blk_q    <= '0;
      out_space_q  <= '0;
    end else begin
      start_q     <= in_acc;
      wr_q        <= fin_go ? res_wr : '0;
      out_valid_q <= fin_go || (out_valid_q && !m_axis_tready);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_NUM_BLOCKS: num_blocks_q <= cfg_data_i[NUM_W-1:0];
          CFG_BLOCK_SIZE: block_size_q <= cfg_data_i[SPACE_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q.func <= s_axis_tdata[2:0];
            cmd_q.idx  <= s_axis_tdata[3 +: BLK_W];
            cmd_q.amt  <= s_axis_tdata[24:9];
            cmd_q.n    <= n_eff;
            state_q    <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok[MAX_BLOCKS]) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_status_q <= res_status;
            out_blk_q    <= CHOSEN_W'(res_blk);
            out_space_q  <= res_space;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_space_q, out_blk_q, out_status_q};

  // At most one cell carries the token.
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok)) else $error("more than one token in the cell row");

  // The token reaches the end of the row only while a search runs.
  a_tok_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_BLOCKS] |-> state_q == S_RUN) else $error("token at row end outside a search");

  // A write to the cells follows the finishing step of a request.
  a_wr_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q.en |-> $past(state_q == S_FIN)) else $error("cell write without a finished request");

  // A failed search reports block zero with no space.
  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status_q == ST_NOFIT) |-> (out_blk_q == '0 && out_space_q == '0))
    else $error("failed search reports a block");

endmodule
